### sv/pvi_pkg.sv
// Package with the shared types, constants and helper functions of the pendulum integrator.
`timescale 1ns / 1ps

package pvi_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_TIME_STEP        = 3'd0;
    localparam logic [2:0] REG_GRAVITY          = 3'd1;
    localparam logic [2:0] REG_LENGTH           = 3'd2;
    localparam logic [2:0] REG_STEP_LIMIT       = 3'd3;
    localparam logic [2:0] REG_INITIAL_ANGLE    = 3'd4;
    localparam logic [2:0] REG_INITIAL_VELOCITY = 3'd5;

    // Register reset values.
    localparam logic [24:0] TIME_STEP_RESET  = 25'd16777;
    localparam logic [23:0] GRAVITY_RESET    = 24'd642908;
    localparam logic [23:0] LENGTH_RESET     = 24'd65536;
    localparam logic [31:0] STEP_LIMIT_RESET = 32'd1000;

    // Angle constants in Q4.28, widened for the reduction arithmetic.
    localparam logic signed [33:0] Q28_PI      = 34'sd843314857;
    localparam logic signed [33:0] Q28_TWO_PI  = 34'sd1686629713;
    localparam logic signed [33:0] Q28_HALF_PI = 34'sd421657428;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd163008219;

    // Quotient bits produced by the restoring divider.
    localparam int DIV_BITS = 54;

    // Arctangent table, round(atan(2^-i) * 2^28).
    localparam logic [27:0] ATAN_TABLE [32] = '{
        28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290,
        28'd16755422,  28'd8385879,   28'd4193963,  28'd2097109,
        28'd1048571,   28'd524287,    28'd262144,   28'd131072,
        28'd65536,     28'd32768,     28'd16384,    28'd8192,
        28'd4096,      28'd2048,      28'd1024,     28'd512,
        28'd256,       28'd128,       28'd64,       28'd32,
        28'd16,        28'd8,         28'd4,        28'd2,
        28'd1,         28'd1,         28'd0,        28'd0
    };

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_DT2,
        OP_MUL_DTV,
        OP_MUL_DT2F,
        OP_ANGLE,
        OP_COR_INIT,
        OP_COR_ITER,
        OP_MAG,
        OP_DIV_PREP,
        OP_DIV_ITER,
        OP_FORCE,
        OP_SET_FORCE,
        OP_VEL_MUL,
        OP_EMIT
    } op_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL_DT2,
        S_MUL_DTV,
        S_MUL_DT2F,
        S_ANGLE,
        S_COR_INIT,
        S_COR_ITER,
        S_MAG,
        S_DIV_PREP,
        S_DIV_ITER,
        S_FORCE,
        S_SET_FORCE,
        S_VEL_MUL,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] iter;
    } cmd_t;

    typedef struct packed {
        logic run_done;
    } status_t;

    // Clip a wide signed value to the signed 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -42'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic sat32_hit(input logic signed [41:0] v);
        return (v > 42'sd2147483647) || (v < -42'sd2147483648);
    endfunction

endpackage

### sv/pvi_controller.sv
// Sequencing state machine of the pendulum integrator.
`timescale 1ns / 1ps

module pvi_controller #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_ready,
    output pvi_pkg::cmd_t    cmd,
    input  pvi_pkg::status_t status
);
    import pvi_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       restart_reg, restart_next;
    logic       out_valid_reg, out_valid_next;
    logic       emit_go;

    // The result slot is free when empty or being taken in this cycle.
    assign emit_go = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        restart_next = restart_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    restart_next = restart;
                    if (restart)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (!status.run_done)
                    begin
                        state_next = S_MUL_DT2;
                    end
                end
            end
            S_LOAD:      state_next = S_COR_INIT;
            S_MUL_DT2:   state_next = S_MUL_DTV;
            S_MUL_DTV:   state_next = S_MUL_DT2F;
            S_MUL_DT2F:  state_next = S_ANGLE;
            S_ANGLE:     state_next = S_COR_INIT;
            S_COR_INIT:
            begin
                cnt_next   = '0;
                state_next = S_COR_ITER;
            end
            S_COR_ITER:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CORDIC_ITERATIONS - 1))
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:       state_next = S_DIV_PREP;
            S_DIV_PREP:
            begin
                cnt_next   = '0;
                state_next = S_DIV_ITER;
            end
            S_DIV_ITER:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_BITS - 1))
                begin
                    state_next = S_FORCE;
                end
            end
            S_FORCE:     state_next = restart_reg ? S_SET_FORCE : S_VEL_MUL;
            S_SET_FORCE: state_next = S_IDLE;
            S_VEL_MUL:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.iter = cnt_reg[4:0];
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:      in_ready = 1'b1;
            S_LOAD:      cmd.op = OP_LOAD;
            S_MUL_DT2:   cmd.op = OP_MUL_DT2;
            S_MUL_DTV:   cmd.op = OP_MUL_DTV;
            S_MUL_DT2F:  cmd.op = OP_MUL_DT2F;
            S_ANGLE:     cmd.op = OP_ANGLE;
            S_COR_INIT:  cmd.op = OP_COR_INIT;
            S_COR_ITER:  cmd.op = OP_COR_ITER;
            S_MAG:       cmd.op = OP_MAG;
            S_DIV_PREP:  cmd.op = OP_DIV_PREP;
            S_DIV_ITER:  cmd.op = OP_DIV_ITER;
            S_FORCE:     cmd.op = OP_FORCE;
            S_SET_FORCE: cmd.op = OP_SET_FORCE;
            S_VEL_MUL:   cmd.op = OP_VEL_MUL;
            S_EMIT:      cmd.op = emit_go ? OP_EMIT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    // Result valid flag: set when a beat is loaded, cleared when it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/pvi_datapath.sv
// Arithmetic datapath, configuration registers and integrator state of the pendulum integrator.
`timescale 1ns / 1ps

module pvi_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  pvi_pkg::cmd_t       cmd,
    output pvi_pkg::status_t    status,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic signed [31:0]  angle_out,
    output logic signed [31:0]  velocity_out,
    output logic [47:0]         time_out,
    output logic [31:0]         step_index,
    output logic                saturated,
    output logic                last_step
);
    import pvi_pkg::*;

    // Configuration registers.
    logic [24:0]        time_step_reg;
    logic [23:0]        gravity_reg;
    logic [23:0]        length_reg;
    logic [31:0]        step_limit_reg;
    logic signed [31:0] init_angle_reg;
    logic signed [31:0] init_velocity_reg;

    // Integrator state.
    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] velocity_reg, velocity_next;
    logic signed [31:0] old_force_reg, old_force_next;
    logic [47:0]        time_reg, time_next;
    logic [31:0]        count_reg, count_next;
    logic               sat_reg, sat_next;

    // Working registers.
    logic signed [60:0] prod_reg, prod_next;
    logic [26:0]        dt2_reg, dt2_next;
    logic signed [41:0] acc_reg, acc_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               neg_reg, neg_next;
    logic [27:0]        rem_reg, rem_next;
    logic [53:0]        num_reg, num_next;
    logic [53:0]        quo_reg, quo_next;
    logic [27:0]        div_reg, div_next;
    logic signed [31:0] force_reg, force_next;

    // Result registers.
    logic signed [31:0] angle_out_reg, angle_out_next;
    logic signed [31:0] velocity_out_reg, velocity_out_next;
    logic [47:0]        time_out_reg, time_out_next;
    logic [31:0]        step_index_reg, step_index_next;
    logic               saturated_reg, saturated_next;
    logic               last_step_reg, last_step_next;

    // Intermediate signals.
    logic signed [27:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;
    logic signed [60:0] rnd20, rnd21, rnd25;
    logic [50:0]        rnd24;
    logic signed [41:0] angle_sum, vel_sum;
    logic signed [33:0] a_ext, z_wrap, z_red;
    logic signed [33:0] x_shift, y_shift, atan_val, y_abs;
    logic [23:0]        len_eff;
    logic [28:0]        trial;
    logic               trial_ge;
    logic               force_hit;
    logic signed [31:0] force_val;
    logic [31:0]        count_inc;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg     <= TIME_STEP_RESET;
            gravity_reg       <= GRAVITY_RESET;
            length_reg        <= LENGTH_RESET;
            step_limit_reg    <= STEP_LIMIT_RESET;
            init_angle_reg    <= '0;
            init_velocity_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:        time_step_reg     <= cfg_data[24:0];
                REG_GRAVITY:          gravity_reg       <= cfg_data[23:0];
                REG_LENGTH:           length_reg        <= cfg_data[23:0];
                REG_STEP_LIMIT:       step_limit_reg    <= cfg_data;
                REG_INITIAL_ANGLE:    init_angle_reg    <= cfg_data;
                REG_INITIAL_VELOCITY: init_velocity_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign status.run_done = count_reg >= step_limit_reg;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_MUL_DT2:
            begin
                mul_a = 28'(time_step_reg);
                mul_b = 33'(time_step_reg);
            end
            OP_MUL_DTV:
            begin
                mul_a = 28'(time_step_reg);
                mul_b = 33'(velocity_reg);
            end
            OP_MUL_DT2F:
            begin
                mul_a = 28'(dt2_reg);
                mul_b = 33'(old_force_reg);
            end
            OP_MAG:
            begin
                mul_a = 28'(gravity_reg);
                mul_b = 33'(y_abs);
            end
            OP_VEL_MUL:
            begin
                mul_a = 28'(time_step_reg);
                mul_b = 33'(force_reg) + 33'(old_force_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Rounded products, to nearest with ties upward.
    assign rnd24 = (51'(prod_reg[49:0]) + 51'd8388608) >> 24;
    assign rnd20 = (prod_reg + 61'sd524288) >>> 20;
    assign rnd21 = (prod_reg + 61'sd1048576) >>> 21;
    assign rnd25 = (prod_reg + 61'sd16777216) >>> 25;
    assign angle_sum = acc_reg + 42'(rnd21);
    assign vel_sum   = 42'(velocity_reg) + 42'(rnd25);

    // Angle reduction to [-pi/2, pi/2].
    always_comb
    begin
        a_ext = 34'(angle_reg);
        if (a_ext > Q28_PI)
        begin
            z_wrap = a_ext - Q28_TWO_PI;
        end
        else if (a_ext < -Q28_PI)
        begin
            z_wrap = a_ext + Q28_TWO_PI;
        end
        else
        begin
            z_wrap = a_ext;
        end
        if (z_wrap > Q28_HALF_PI)
        begin
            z_red = Q28_PI - z_wrap;
        end
        else if (z_wrap < -Q28_HALF_PI)
        begin
            z_red = -Q28_PI - z_wrap;
        end
        else
        begin
            z_red = z_wrap;
        end
    end

    // CORDIC shifts and magnitude of the sine.
    assign x_shift  = x_reg >>> cmd.iter;
    assign y_shift  = y_reg >>> cmd.iter;
    assign atan_val = 34'(ATAN_TABLE[cmd.iter]);
    assign y_abs    = y_reg[33] ? -y_reg : y_reg;

    // Divider step and zero length guard.
    assign len_eff  = (length_reg == '0) ? 24'd1 : length_reg;
    assign trial    = {rem_reg, num_reg[53]};
    assign trial_ge = trial >= {1'b0, div_reg};

    // Force from the rounded quotient, with clipping.
    always_comb
    begin
        if (neg_reg)
        begin
            force_hit = quo_reg > 54'd2147483647;
            force_val = force_hit ? 32'sh7FFFFFFF : quo_reg[31:0];
        end
        else
        begin
            force_hit = quo_reg > 54'd2147483648;
            force_val = force_hit ? 32'sh80000000 : 32'(32'd0 - quo_reg[31:0]);
        end
    end

    assign count_inc = count_reg + 32'd1;

    // Datapath register updates per command.
    always_comb
    begin
        angle_next        = angle_reg;
        velocity_next     = velocity_reg;
        old_force_next    = old_force_reg;
        time_next         = time_reg;
        count_next        = count_reg;
        sat_next          = sat_reg;
        prod_next         = mul_en ? mul_a * mul_b : prod_reg;
        dt2_next          = dt2_reg;
        acc_next          = acc_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        neg_next          = neg_reg;
        rem_next          = rem_reg;
        num_next          = num_reg;
        quo_next          = quo_reg;
        div_next          = div_reg;
        force_next        = force_reg;
        angle_out_next    = angle_out_reg;
        velocity_out_next = velocity_out_reg;
        time_out_next     = time_out_reg;
        step_index_next   = step_index_reg;
        saturated_next    = saturated_reg;
        last_step_next    = last_step_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                angle_next    = init_angle_reg;
                velocity_next = init_velocity_reg;
                time_next     = '0;
                count_next    = '0;
            end
            OP_MUL_DT2:
            begin
                sat_next = 1'b0;
            end
            OP_MUL_DTV:
            begin
                dt2_next = rnd24[26:0];
            end
            OP_MUL_DT2F:
            begin
                acc_next = 42'(angle_reg) + 42'(rnd20);
            end
            OP_ANGLE:
            begin
                angle_next = sat32(angle_sum);
                sat_next   = sat_reg | sat32_hit(angle_sum);
            end
            OP_COR_INIT:
            begin
                x_next = CORDIC_GAIN;
                y_next = '0;
                z_next = z_red;
            end
            OP_COR_ITER:
            begin
                if (!z_reg[33])
                begin
                    x_next = x_reg - y_shift;
                    y_next = y_reg + x_shift;
                    z_next = z_reg - atan_val;
                end
                else
                begin
                    x_next = x_reg + y_shift;
                    y_next = y_reg - x_shift;
                    z_next = z_reg + atan_val;
                end
            end
            OP_MAG:
            begin
                neg_next = y_reg[33];
            end
            OP_DIV_PREP:
            begin
                num_next = prod_reg[53:0] + 54'({len_eff, 3'b000});
                div_next = {len_eff, 4'b0000};
                rem_next = '0;
                quo_next = '0;
            end
            OP_DIV_ITER:
            begin
                rem_next = trial_ge ? 28'(trial - {1'b0, div_reg}) : trial[27:0];
                num_next = {num_reg[52:0], 1'b0};
                quo_next = {quo_reg[52:0], trial_ge};
            end
            OP_FORCE:
            begin
                force_next = force_val;
                sat_next   = sat_reg | force_hit;
            end
            OP_SET_FORCE:
            begin
                old_force_next = force_reg;
            end
            OP_EMIT:
            begin
                velocity_next     = sat32(vel_sum);
                old_force_next    = force_reg;
                time_next         = time_reg + 48'(time_step_reg);
                count_next        = count_inc;
                angle_out_next    = angle_reg;
                velocity_out_next = sat32(vel_sum);
                time_out_next     = time_reg + 48'(time_step_reg);
                step_index_next   = count_inc;
                saturated_next    = sat_reg | sat32_hit(vel_sum);
                last_step_next    = count_inc == step_limit_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Integrator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg     <= '0;
            velocity_reg  <= '0;
            old_force_reg <= '0;
            time_reg      <= '0;
            count_reg     <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            angle_reg     <= angle_next;
            velocity_reg  <= velocity_next;
            old_force_reg <= old_force_next;
            time_reg      <= time_next;
            count_reg     <= count_next;
            sat_reg       <= sat_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        prod_reg         <= prod_next;
        dt2_reg          <= dt2_next;
        acc_reg          <= acc_next;
        x_reg            <= x_next;
        y_reg            <= y_next;
        z_reg            <= z_next;
        neg_reg          <= neg_next;
        rem_reg          <= rem_next;
        num_reg          <= num_next;
        quo_reg          <= quo_next;
        div_reg          <= div_next;
        force_reg        <= force_next;
        angle_out_reg    <= angle_out_next;
        velocity_out_reg <= velocity_out_next;
        time_out_reg     <= time_out_next;
        step_index_reg   <= step_index_next;
        saturated_reg    <= saturated_next;
        last_step_reg    <= last_step_next;
    end

    assign angle_out    = angle_out_reg;
    assign velocity_out = velocity_out_reg;
    assign time_out     = time_out_reg;
    assign step_index   = step_index_reg;
    assign saturated    = saturated_reg;
    assign last_step    = last_step_reg;

endmodule

### sv/pendulum_verlet_integrator_unit.sv
// Top level of the velocity Verlet pendulum integrator.
`timescale 1ns / 1ps
// Usage: each input beat carries one restart bit. A beat with restart high reloads the
// initial angle and velocity, clears time and step count, computes the first force and
// returns no result. A beat with restart low advances one time step and returns one
// result beat (angle, velocity, elapsed time, step index, saturation and last-step flags),
// or nothing once the configured number of steps has been run.
// Flow: an advancing beat keeps in_ready low from its acceptance until its result is loaded
// into the output register; a restart keeps in_ready low until the first force is stored.
// in_ready is high only between items, so a new beat is taken only once the last one is
// through. The work is the angle update, then the one-iteration-per-cycle CORDIC sine and
// the one-bit-per-cycle restoring divider for the division by length, with setup, force
// and velocity steps around them.
// The result sits in an output register, so the next item is accepted while it waits;
// if the receiver still stalls when the following result is ready, the block holds in
// its last cycle until the slot frees up.
// Configuration is written through cfg_write/cfg_index/cfg_data while the block is idle.
// Reset: configuration registers take their default values, the state is cleared and no beat is pending.
module pendulum_verlet_integrator_unit #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] angle_out,
    output logic signed [31:0] velocity_out,
    output logic [47:0]        time_out,
    output logic [31:0]        step_index,
    output logic               saturated,
    output logic               last_step
);
    import pvi_pkg::*;

    cmd_t    cmd;
    status_t status;

    pvi_controller #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    pvi_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .angle_out    (angle_out),
        .velocity_out (velocity_out),
        .time_out     (time_out),
        .step_index   (step_index),
        .saturated    (saturated),
        .last_step    (last_step)
    );

endmodule
